// ----- sv/keyframe_vec3_interpolator_defines.svh -----
// assertion macros for the keyframe vec3 interpolator
// used by the top level only
`ifndef KEYFRAME_VEC3_INTERPOLATOR_DEFINES_SVH
`define KEYFRAME_VEC3_INTERPOLATOR_DEFINES_SVH

// implication checked at every clock edge outside reset
`define KVI_ASSERT_IMPL(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define KVI_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

// ----- sv/kvi_pkg.sv -----
// shared types and constants for the keyframe vec3 interpolator
// no dependencies
package kvi_pkg;

   localparam int MAX_KEYS_DEF = 64;
   localparam int CNT_W = 7;
   localparam int DATA_W = 32;
   localparam int STATUS_W = 3;
   localparam int IDX_W = 6;

   localparam logic CMD_EVAL = 1'b0;
   localparam logic CMD_LOAD = 1'b1;

   typedef enum logic [2:0] {
      ST_INTERP  = 3'd0,
      ST_CLAMP_LO = 3'd1,
      ST_CLAMP_HI = 3'd2,
      ST_HELD    = 3'd3,
      ST_EMPTY   = 3'd4
   } status_type;

   // one queued request
   typedef struct packed {
      logic                     cmd;
      logic [IDX_W-1:0]         idx;
      logic signed [DATA_W-1:0] key_time;
      logic signed [DATA_W-1:0] vx;
      logic signed [DATA_W-1:0] vy;
      logic signed [DATA_W-1:0] vz;
      logic signed [DATA_W-1:0] frac;
   } req_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_RD0,
      S_CHK0,
      S_RDN,
      S_CHKN,
      S_SCAN_RD,
      S_SCAN_CHK,
      S_DIV,
      S_MUL,
      S_ADD,
      S_OUT
   } eng_state_type;

endpackage

// ----- sv/kvi_front.sv -----
// front end: accepts requests into a short queue
// depends on kvi_pkg
module kvi_front #(
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  kvi_pkg::req_type in_req,
   output logic             out_valid,
   input  logic             out_ready,
   output kvi_pkg::req_type out_req
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   kvi_pkg::req_type mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [AW:0]   cnt_ff, cnt_in;
   logic push, pop;

   assign in_ready  = (cnt_ff != (AW+1)'(DEPTH));
   assign out_valid = (cnt_ff != '0);
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;
   assign out_req = mem_ff[rp_ff];

   // pointer update
   always_comb begin
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      if (push) wp_in = (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
      if (pop)  rp_in = (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_req;
   end
endmodule

// ----- sv/kvi_div.sv -----
// iterative unsigned divider, one quotient bit per cycle
// no package dependencies
module kvi_div #(
   parameter int NW = 48,
   parameter int DW = 33
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quo
);
   localparam int CW = $clog2(NW+1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW:0]   r_ff, r_in;
   logic [DW-1:0] d_ff, d_in;
   logic [CW-1:0] c_ff, c_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [DW:0]   trial;

   assign done = done_ff;
   assign quo  = q_ff;
   assign trial = {r_ff[DW-1:0], q_ff[NW-1]};

   // restoring division step
   always_comb begin
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      c_in = c_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         c_in = CW'(NW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, d_ff}) begin
            r_in = trial - {1'b0, d_ff};
            q_in = {q_ff[NW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[NW-2:0], 1'b0};
         end
         c_in = c_ff - 1'b1;
         if (c_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
      c_ff <= c_in;
   end
endmodule

// ----- sv/kvi_engine.sv -----
// back end: key tables, segment scan, weight division and blend
// depends on kvi_pkg and kvi_div
module kvi_engine #(
   parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [kvi_pkg::CNT_W-1:0]         key_count,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  kvi_pkg::req_type                  in_req,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic signed [kvi_pkg::DATA_W-1:0] out_x,
   output logic signed [kvi_pkg::DATA_W-1:0] out_y,
   output logic signed [kvi_pkg::DATA_W-1:0] out_z,
   output kvi_pkg::status_type               out_status
);
   localparam int AW = $clog2(MAX_KEYS);
   localparam int DW = kvi_pkg::DATA_W;
   localparam int KW = $clog2(MAX_KEYS+1);
   localparam int IW = kvi_pkg::IDX_W;

   // key memories, one read port
   logic signed [DW-1:0] mt [MAX_KEYS];
   logic signed [DW-1:0] mx [MAX_KEYS];
   logic signed [DW-1:0] my [MAX_KEYS];
   logic signed [DW-1:0] mz [MAX_KEYS];
   logic signed [DW-1:0] rt_ff, rx_ff, ry_ff, rz_ff;
   logic [AW-1:0] raddr;

   kvi_pkg::eng_state_type st_ff, st_in;
   logic [KW-1:0] cnt_ff, cnt_in;
   logic [KW-1:0] i_ff, i_in;
   logic signed [DW-1:0] f_ff;
   logic signed [DW-1:0] t0_ff, x0_ff, y0_ff, z0_ff;
   logic signed [DW-1:0] t0_in, x0_in, y0_in, z0_in;
   logic signed [DW:0]   dx_ff, dy_ff, dz_ff;
   logic [16:0]          w_ff;
   logic [DW+17:0]       px_ff, py_ff, pz_ff;
   logic signed [DW-1:0] lx_ff, ly_ff, lz_ff, lx_in, ly_in, lz_in;
   logic signed [DW-1:0] ox_ff, oy_ff, oz_ff, ox_in, oy_in, oz_in;
   kvi_pkg::status_type  os_ff, os_in;
   logic                 ov_ff, ov_in;
   logic                 take, div_start, div_done;
   logic [47:0]          div_num, div_q;
   logic [DW:0]          div_den;
   logic [KW-1:0]        eff_cnt;
   logic [DW:0]          seg_d, seg_n;

   assign in_ready = (st_ff == kvi_pkg::S_IDLE) && !ov_ff;
   assign take = in_valid && in_ready;
   assign out_valid = ov_ff;
   assign out_x = ox_ff;
   assign out_y = oy_ff;
   assign out_z = oz_ff;
   assign out_status = os_ff;

   assign eff_cnt = (32'(key_count) > 32'(MAX_KEYS)) ? KW'(MAX_KEYS)
                                                     : KW'(key_count);

   // table write
   always_ff @(posedge clock) begin
      if (take && in_req.cmd == kvi_pkg::CMD_LOAD &&
          {{(32-IW){1'b0}}, in_req.idx} < 32'(MAX_KEYS)) begin
         mt[AW'(in_req.idx)] <= in_req.key_time;
         mx[AW'(in_req.idx)] <= in_req.vx;
         my[AW'(in_req.idx)] <= in_req.vy;
         mz[AW'(in_req.idx)] <= in_req.vz;
      end
   end

   // registered table read
   always_ff @(posedge clock) begin
      rt_ff <= mt[raddr];
      rx_ff <= mx[raddr];
      ry_ff <= my[raddr];
      rz_ff <= mz[raddr];
   end

   // segment width and offset
   assign seg_d = {rt_ff[DW-1], rt_ff} - {t0_ff[DW-1], t0_ff};
   assign seg_n = {f_ff[DW-1], f_ff} - {t0_ff[DW-1], t0_ff};
   assign div_num = {seg_n[31:0], 16'h0};
   assign div_den = seg_d;
   assign div_start = (st_ff == kvi_pkg::S_SCAN_CHK) && (f_ff >= t0_ff) &&
                      (f_ff <= rt_ff) && (seg_d != '0);

   kvi_div #(.NW(48), .DW(DW+1)) u_div (
      .clock(clock), .reset(reset), .start(div_start),
      .num(div_num), .den(div_den), .done(div_done), .quo(div_q)
   );

   // next state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         kvi_pkg::S_IDLE:
            if (take && in_req.cmd == kvi_pkg::CMD_EVAL)
               st_in = (eff_cnt == '0) ? kvi_pkg::S_OUT : kvi_pkg::S_RD0;
         kvi_pkg::S_RD0: st_in = kvi_pkg::S_CHK0;
         kvi_pkg::S_CHK0:
            st_in = (f_ff < rt_ff) ? kvi_pkg::S_OUT : kvi_pkg::S_RDN;
         kvi_pkg::S_RDN: st_in = kvi_pkg::S_CHKN;
         kvi_pkg::S_CHKN:
            st_in = (f_ff > rt_ff) ? kvi_pkg::S_OUT : kvi_pkg::S_SCAN_RD;
         kvi_pkg::S_SCAN_RD:
            st_in = (i_ff >= cnt_ff) ? kvi_pkg::S_OUT : kvi_pkg::S_SCAN_CHK;
         kvi_pkg::S_SCAN_CHK:
            priority if (f_ff >= t0_ff && f_ff <= rt_ff)
               st_in = div_start ? kvi_pkg::S_DIV : kvi_pkg::S_MUL;
            else st_in = kvi_pkg::S_SCAN_RD;
         kvi_pkg::S_DIV: if (div_done) st_in = kvi_pkg::S_MUL;
         kvi_pkg::S_MUL: st_in = kvi_pkg::S_ADD;
         kvi_pkg::S_ADD: st_in = kvi_pkg::S_OUT;
         kvi_pkg::S_OUT: st_in = kvi_pkg::S_IDLE;
         default: st_in = kvi_pkg::S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      raddr = '0;
      cnt_in = cnt_ff;
      i_in = i_ff;
      t0_in = t0_ff; x0_in = x0_ff; y0_in = y0_ff; z0_in = z0_ff;
      lx_in = lx_ff; ly_in = ly_ff; lz_in = lz_ff;
      ox_in = ox_ff; oy_in = oy_ff; oz_in = oz_ff;
      os_in = os_ff;
      ov_in = ov_ff && !out_ready;
      unique case (st_ff)
         kvi_pkg::S_IDLE: begin
            cnt_in = eff_cnt;
            i_in = KW'(1);
            if (take && in_req.cmd == kvi_pkg::CMD_EVAL && eff_cnt == '0) begin
               ox_in = '0; oy_in = '0; oz_in = '0;
               os_in = kvi_pkg::ST_EMPTY;
            end
         end
         kvi_pkg::S_CHK0: begin
            raddr = AW'(cnt_ff - 1'b1);
            t0_in = rt_ff; x0_in = rx_ff; y0_in = ry_ff; z0_in = rz_ff;
            if (f_ff < rt_ff) begin
               lx_in = rx_ff; ly_in = ry_ff; lz_in = rz_ff;
               ox_in = rx_ff; oy_in = ry_ff; oz_in = rz_ff;
               os_in = kvi_pkg::ST_CLAMP_LO;
            end
         end
         kvi_pkg::S_RDN: raddr = AW'(cnt_ff - 1'b1);
         kvi_pkg::S_CHKN: begin
            raddr = AW'(i_ff);
            if (f_ff > rt_ff) begin
               lx_in = rx_ff; ly_in = ry_ff; lz_in = rz_ff;
               ox_in = rx_ff; oy_in = ry_ff; oz_in = rz_ff;
               os_in = kvi_pkg::ST_CLAMP_HI;
            end
         end
         kvi_pkg::S_SCAN_RD: begin
            raddr = AW'(i_ff);
            if (i_ff >= cnt_ff) begin
               ox_in = lx_ff; oy_in = ly_ff; oz_in = lz_ff;
               os_in = kvi_pkg::ST_HELD;
            end
         end
         kvi_pkg::S_SCAN_CHK: begin
            if (!(f_ff >= t0_ff && f_ff <= rt_ff)) begin
               t0_in = rt_ff; x0_in = rx_ff; y0_in = ry_ff; z0_in = rz_ff;
               i_in = i_ff + 1'b1;
               raddr = AW'(i_ff + 1'b1);
            end
         end
         kvi_pkg::S_ADD: begin
            lx_in = x0_ff + px_ff[DW-1:0];
            ly_in = y0_ff + py_ff[DW-1:0];
            lz_in = z0_ff + pz_ff[DW-1:0];
            ox_in = x0_ff + px_ff[DW-1:0];
            oy_in = y0_ff + py_ff[DW-1:0];
            oz_in = z0_ff + pz_ff[DW-1:0];
            os_in = kvi_pkg::ST_INTERP;
         end
         kvi_pkg::S_OUT: ov_in = 1'b1;
         default: ;
      endcase
   end

   // scaled difference with rounding toward minus infinity
   function automatic logic [DW+17:0] scale(input logic signed [DW:0] d,
                                           input logic [16:0] w);
      logic [DW:0]    mag;
      logic [DW+17:0] p;
      logic [DW+17:0] q;
      mag = d[DW] ? (~d + 1'b1) : d;
      p = {17'h0, mag} * {{(DW+1){1'b0}}, w};
      if (d[DW]) begin
         q = (p + (DW+18)'(65535)) >> 16;
         scale = ~q + 1'b1;
      end else scale = p >> 16;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= kvi_pkg::S_IDLE;
         ov_ff <= 1'b0;
         lx_ff <= '0; ly_ff <= '0; lz_ff <= '0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         lx_ff <= lx_in; ly_ff <= ly_in; lz_ff <= lz_in;
      end
      if (take) f_ff <= in_req.frac;
      cnt_ff <= cnt_in;
      i_ff <= i_in;
      t0_ff <= t0_in; x0_ff <= x0_in; y0_ff <= y0_in; z0_ff <= z0_in;
      ox_ff <= ox_in; oy_ff <= oy_in; oz_ff <= oz_in;
      os_ff <= os_in;
      // capture segment end differences and weight
      if (st_ff == kvi_pkg::S_SCAN_CHK) begin
         dx_ff <= {rx_ff[DW-1], rx_ff} - {x0_ff[DW-1], x0_ff};
         dy_ff <= {ry_ff[DW-1], ry_ff} - {y0_ff[DW-1], y0_ff};
         dz_ff <= {rz_ff[DW-1], rz_ff} - {z0_ff[DW-1], z0_ff};
         w_ff <= '0;
      end
      if (st_ff == kvi_pkg::S_DIV && div_done) w_ff <= div_q[16:0];
      if (st_ff == kvi_pkg::S_MUL) begin
         px_ff <= scale(dx_ff, w_ff);
         py_ff <= scale(dy_ff, w_ff);
         pz_ff <= scale(dz_ff, w_ff);
      end
   end
endmodule

// ----- sv/keyframe_vec3_interpolator.sv -----
// top level of the keyframe vec3 interpolator
// depends on kvi_pkg, kvi_front, kvi_engine and the defines header
//
//  channel | direction | fields
//  req_    | in        | command, entry_index, key_time, value_x/y/z, fraction
//  rsp_    | out       | out_x, out_y, out_z, status
//  csr_    | in        | key_count
//
// a load is written into the key tables on accept and leaves the engine idle; an
// evaluate checks the first key, then the last, then scans segments, and for a
// segment of nonzero width runs the bit-serial weight divider before the blend.
// the segment scan through the single-port key memory grows with the key count.
// reset is synchronous and active high; the key tables are not cleared.
// a four-deep request queue keeps accepting while results wait.
`include "keyframe_vec3_interpolator_defines.svh"
module keyframe_vec3_interpolator #(
   parameter int MAX_KEYS = kvi_pkg::MAX_KEYS_DEF
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   // entry_index[5:0], key_time[37:6], value_x[69:38], value_y[101:70],
   // value_z[133:102], fraction[165:134], zero fill to 168
   input  logic [167:0]  req_tdata,
   // command
   input  logic          req_tuser,
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   // out_x[31:0], out_y[63:32], out_z[95:64], status[98:96], zero fill to 104
   output logic [103:0]  rsp_tdata,
   input  logic          csr_we,
   input  logic [6:0]    csr_wdata
);
   kvi_pkg::req_type in_req, q_req;
   logic q_valid, q_ready;
   logic [kvi_pkg::CNT_W-1:0] key_count_ff;
   logic signed [31:0] ox, oy, oz;
   kvi_pkg::status_type os;

   // key count register
   always_ff @(posedge clock) begin
      if (reset) key_count_ff <= '0;
      else if (csr_we) key_count_ff <= csr_wdata;
   end

   // unpack request
   always_comb begin
      in_req.cmd = req_tuser;
      in_req.idx = req_tdata[5:0];
      in_req.key_time = req_tdata[37:6];
      in_req.vx = req_tdata[69:38];
      in_req.vy = req_tdata[101:70];
      in_req.vz = req_tdata[133:102];
      in_req.frac = req_tdata[165:134];
   end

   kvi_front #(.DEPTH(4)) u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_req(in_req),
      .out_valid(q_valid), .out_ready(q_ready), .out_req(q_req)
   );

   kvi_engine #(.MAX_KEYS(MAX_KEYS)) u_engine (
      .clock(clock), .reset(reset), .key_count(key_count_ff),
      .in_valid(q_valid), .in_ready(q_ready), .in_req(q_req),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .out_x(ox), .out_y(oy), .out_z(oz), .out_status(os)
   );

   assign rsp_tdata = {5'b0, os, oz, oy, ox};

   // checks
   `KVI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))
   `KVI_ASSERT_IMPL(a_empty_zero, clock, reset, rsp_tvalid && rsp_tdata[98:96] == kvi_pkg::ST_EMPTY, rsp_tdata[95:0] == '0)
   `KVI_ASSERT_IMPL(a_status_range, clock, reset, rsp_tvalid, rsp_tdata[98:96] <= kvi_pkg::ST_EMPTY)
endmodule
